[hw/rtl/mcfe_pkg.sv]
package mcfe_pkg;

  localparam int CODE_W    = 16;           // widest code (position)
  localparam int DIV_STEPS = CODE_W + 1;   // quotient bits, one extra to see overflow
  localparam int QUO_W     = DIV_STEPS;
  localparam int BND_W     = 34;           // signed range ends and differences
  localparam int SPAN_W    = 33;           // positive span / in-range difference
  localparam int NUM_W     = SPAN_W + CODE_W + 1;
  localparam int LANE_LAT  = DIV_STEPS + 2; // prep + load + divide steps
  localparam int REG_W     = 31;

  localparam logic [63:0] NEUTRAL_PAYLOAD = 64'h7FFF_7FF0_0000_07FF;

  typedef enum logic [2:0] {
    REG_POS_LIMIT = 3'd0,
    REG_VEL_LIMIT = 3'd1,
    REG_TOR_LIMIT = 3'd2,
    REG_KP_LOW    = 3'd3,
    REG_KP_HIGH   = 3'd4,
    REG_KD_LOW    = 3'd5,
    REG_KD_HIGH   = 3'd6
  } cfg_reg_t;

  typedef logic signed [BND_W-1:0] bound_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              clamp;
  } lane_res_t;

endpackage

[hw/rtl/mcfe_lane.sv]
module mcfe_lane #(
  parameter int BITS = 12
) (
  input  logic                   clk,
  input  logic signed [31:0]     x,
  input  mcfe_pkg::bound_t       lo,
  input  mcfe_pkg::bound_t       hi,
  output mcfe_pkg::lane_res_t    res
);
  import mcfe_pkg::*;

  localparam logic [CODE_W-1:0] FULL = CODE_W'((64'd1 << BITS) - 64'd1);

  bound_t diff_r, span_r;
  logic              bad, big;
  logic [SPAN_W-1:0] diff_u;
  logic [NUM_W-1:0]  num;

  logic [NUM_W-1:0]  rem_r [0:DIV_STEPS];
  logic [QUO_W-1:0]  quo_r [0:DIV_STEPS];
  logic [SPAN_W-1:0] spn_r [0:DIV_STEPS];
  logic              bad_r [0:DIV_STEPS];
  logic              big_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    diff_r <= bound_t'({{(BND_W-32){x[31]}}, x}) - lo;
    span_r <= hi - lo;
  end

  // empty range or below it -> 0; at or past twice the span -> surely saturated
  always_comb begin
    bad    = (span_r <= 0) || (diff_r < 0);
    big    = {diff_r[BND_W-1], diff_r} >= {span_r, 1'b0};
    diff_u = diff_r[SPAN_W-1:0];
    num    = (bad || big) ? '0
           : (NUM_W'(diff_u) << BITS) - NUM_W'(diff_u);
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    quo_r[0] <= '0;
    spn_r[0] <= span_r[SPAN_W-1:0];
    bad_r[0] <= bad;
    big_r[0] <= big;
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - i;
    logic [NUM_W-1:0] trial;
    logic             ge;
    assign trial = NUM_W'(spn_r[i]) << SH;
    assign ge    = rem_r[i] >= trial;
    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? rem_r[i] - trial : rem_r[i];
      quo_r[i+1] <= {quo_r[i][QUO_W-2:0], ge};
      spn_r[i+1] <= spn_r[i];
      bad_r[i+1] <= bad_r[i];
      big_r[i+1] <= big_r[i];
    end
  end

  always_comb begin
    if (bad_r[DIV_STEPS]) begin
      res.code  = '0;
      res.clamp = 1'b1;
    end else if (big_r[DIV_STEPS] || (quo_r[DIV_STEPS] > {1'b0, FULL})) begin
      res.code  = FULL;
      res.clamp = 1'b1;
    end else begin
      res.code  = quo_r[DIV_STEPS][CODE_W-1:0];
      res.clamp = 1'b0;
    end
  end

endmodule

[hw/rtl/mcfe_cfg.sv]
module mcfe_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         we,
  input  logic [2:0]                   index,
  input  logic [mcfe_pkg::REG_W-1:0]   data,
  output mcfe_pkg::bound_t             pos_lo,
  output mcfe_pkg::bound_t             pos_hi,
  output mcfe_pkg::bound_t             vel_lo,
  output mcfe_pkg::bound_t             vel_hi,
  output mcfe_pkg::bound_t             tor_lo,
  output mcfe_pkg::bound_t             tor_hi,
  output mcfe_pkg::bound_t             kp_lo,
  output mcfe_pkg::bound_t             kp_hi,
  output mcfe_pkg::bound_t             kd_lo,
  output mcfe_pkg::bound_t             kd_hi
);
  import mcfe_pkg::*;

  logic [REG_W-1:0] pos_lim_r, vel_lim_r, tor_lim_r, kp_low_r, kp_high_r, kd_low_r, kd_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_lim_r <= REG_W'(205887);
      vel_lim_r <= REG_W'(1966080);
      tor_lim_r <= REG_W'(655360);
      kp_low_r  <= '0;
      kp_high_r <= REG_W'(32768000);
      kd_low_r  <= '0;
      kd_high_r <= REG_W'(327680);
    end else if (we) begin
      unique case (cfg_reg_t'(index))
        REG_POS_LIMIT: pos_lim_r <= data;
        REG_VEL_LIMIT: vel_lim_r <= data;
        REG_TOR_LIMIT: tor_lim_r <= data;
        REG_KP_LOW:    kp_low_r  <= data;
        REG_KP_HIGH:   kp_high_r <= data;
        REG_KD_LOW:    kd_low_r  <= data;
        REG_KD_HIGH:   kd_high_r <= data;
        default: ;
      endcase
    end
  end

  assign pos_hi = bound_t'({3'b000, pos_lim_r});
  assign pos_lo = -pos_hi;
  assign vel_hi = bound_t'({3'b000, vel_lim_r});
  assign vel_lo = -vel_hi;
  assign tor_hi = bound_t'({3'b000, tor_lim_r});
  assign tor_lo = -tor_hi;
  assign kp_lo  = bound_t'({3'b000, kp_low_r});
  assign kp_hi  = bound_t'({3'b000, kp_high_r});
  assign kd_lo  = bound_t'({3'b000, kd_low_r});
  assign kd_hi  = bound_t'({3'b000, kd_high_r});

endmodule

[hw/rtl/mit_command_frame_encoder_top.sv]
// Channel   Handshake                 Payload
// input     start / busy              in_enabled, in_node_id, in_target_position,
//                                     in_target_velocity, in_feedforward_torque,
//                                     in_stiffness_gain, in_damping_gain
// result    out_valid (1-cycle strobe) out_frame_id, out_payload, out_clamped
// config    cfg_we                    cfg_index, cfg_data
//
// One word is taken per cycle; busy is never raised.
// A word's frame reaches the result ports via the input registers, each lane's
// prep, load and 17-step one-bit-per-stage divider, and the output register.
// Reset (synchronous, rst_n low) clears the valid pipeline and loads the default
// ranges; data registers are not reset.
// The receiver cannot stall: every frame is shown for one cycle only.
module mit_command_frame_encoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_enabled,
  input  logic [7:0]                  in_node_id,
  input  logic signed [31:0]          in_target_position,
  input  logic signed [31:0]          in_target_velocity,
  input  logic signed [31:0]          in_feedforward_torque,
  input  logic signed [31:0]          in_stiffness_gain,
  input  logic signed [31:0]          in_damping_gain,
  output logic                        out_valid,
  output logic [7:0]                  out_frame_id,
  output logic [63:0]                 out_payload,
  output logic                        out_clamped,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [mcfe_pkg::REG_W-1:0]  cfg_data
);
  import mcfe_pkg::*;

  logic accept;

  // word tags ride alongside the lanes
  logic       vld_r [0:LANE_LAT];
  logic       en_r  [0:LANE_LAT];
  logic [7:0] id_r  [0:LANE_LAT];

  // input registers feeding the lanes
  logic signed [31:0] pos_r, vel_r, tor_r, kp_r, kd_r;

  bound_t pos_lo, pos_hi, vel_lo, vel_hi, tor_lo, tor_hi, kp_lo, kp_hi, kd_lo, kd_hi;
  lane_res_t pos_res, vel_res, tor_res, kp_res, kd_res;

  logic        out_valid_r;
  logic [7:0]  out_id_r;
  logic [63:0] out_payload_r, payload_nxt;
  logic        out_clamped_r, clamped_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mcfe_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (cfg_we),
    .index  (cfg_index),
    .data   (cfg_data),
    .pos_lo (pos_lo), .pos_hi (pos_hi),
    .vel_lo (vel_lo), .vel_hi (vel_hi),
    .tor_lo (tor_lo), .tor_hi (tor_hi),
    .kp_lo  (kp_lo),  .kp_hi  (kp_hi),
    .kd_lo  (kd_lo),  .kd_hi  (kd_hi)
  );

  always_ff @(posedge clk) begin
    pos_r <= in_target_position;
    vel_r <= in_target_velocity;
    tor_r <= in_feedforward_torque;
    kp_r  <= in_stiffness_gain;
    kd_r  <= in_damping_gain;
    en_r[0] <= in_enabled;
    id_r[0] <= in_node_id;
    for (int i = 1; i <= LANE_LAT; i++) begin
      en_r[i] <= en_r[i-1];
      id_r[i] <= id_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LANE_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i <= LANE_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // five quantizer lanes in parallel
  mcfe_lane #(.BITS(16)) u_pos (.clk(clk), .x(pos_r), .lo(pos_lo), .hi(pos_hi), .res(pos_res));
  mcfe_lane #(.BITS(12)) u_vel (.clk(clk), .x(vel_r), .lo(vel_lo), .hi(vel_hi), .res(vel_res));
  mcfe_lane #(.BITS(12)) u_tor (.clk(clk), .x(tor_r), .lo(tor_lo), .hi(tor_hi), .res(tor_res));
  mcfe_lane #(.BITS(12)) u_kp  (.clk(clk), .x(kp_r),  .lo(kp_lo),  .hi(kp_hi),  .res(kp_res));
  mcfe_lane #(.BITS(12)) u_kd  (.clk(clk), .x(kd_r),  .lo(kd_lo),  .hi(kd_hi),  .res(kd_res));

  // merge: big-endian pack pos, vel, kp, kd, tor; disabled motor gets neutral frame
  always_comb begin
    if (en_r[LANE_LAT]) begin
      payload_nxt = {pos_res.code, vel_res.code[11:0], kp_res.code[11:0],
                     kd_res.code[11:0], tor_res.code[11:0]};
      clamped_nxt = pos_res.clamp | vel_res.clamp | tor_res.clamp |
                    kp_res.clamp | kd_res.clamp;
    end else begin
      payload_nxt = NEUTRAL_PAYLOAD;
      clamped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_id_r      <= id_r[LANE_LAT];
    out_payload_r <= payload_nxt;
    out_clamped_r <= clamped_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vld_r[LANE_LAT];
  end

  assign out_valid    = out_valid_r;
  assign out_frame_id = out_id_r;
  assign out_payload  = out_payload_r;
  assign out_clamped  = out_clamped_r;

endmodule

[hw/rtl/mcfe_checker.sv]
module mcfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_enabled,
  input logic [7:0]  in_node_id,
  input logic        out_valid,
  input logic [7:0]  out_frame_id,
  input logic [63:0] out_payload,
  input logic        out_clamped
);

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 21))
    else $error("frame without a command 21 cycles earlier");

  a_frame_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_id == $past(in_node_id, 21))
    else $error("frame id does not match node id");

  a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(in_enabled, 21)) |->
      (out_payload == 64'h7FFF_7FF0_0000_07FF && !out_clamped))
    else $error("disabled motor frame not neutral");

endmodule

bind mit_command_frame_encoder_top mcfe_checker u_mcfe_checker (.*);
